@@ sv/pfsc_pkg.sv @@
// pump fill safety controller: shared types, register indexes and constants
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pfsc_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_TIMER_W = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_RUN       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SUMP_LOCKOUT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TANK_LOCKOUT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MANUAL_TMO    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FLOW_CHECK    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_RISE      = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_TRIG   = 3'd7;

    // register defaults
    localparam logic [CFG_TIMER_W-1:0] DEF_DEBOUNCE_MS     = 24'd3000;
    localparam logic [CFG_TIMER_W-1:0] DEF_MIN_RUN_MS      = 24'd30000;
    localparam logic [CFG_TIMER_W-1:0] DEF_SUMP_LOCKOUT_MS = 24'd600000;
    localparam logic [CFG_TIMER_W-1:0] DEF_TANK_LOCKOUT_MS = 24'd1800000;
    localparam logic [CFG_TIMER_W-1:0] DEF_MANUAL_TMO_MS   = 24'd900000;
    localparam logic [CFG_TIMER_W-1:0] DEF_FLOW_CHECK_MS   = 24'd60000;
    localparam logic [7:0]             DEF_MIN_RISE_CM     = 8'd2;
    localparam logic [6:0]             DEF_NORMAL_TRIG     = 7'd60;

    // fill levels in percent
    localparam logic [6:0] TOPUP_TRIGGER = 7'd90;
    localparam logic [6:0] FULL_PERCENT  = 7'd100;

    // run length bookkeeping
    localparam int          SUBSEC_W     = 10;
    localparam logic [SUBSEC_W-1:0] LAST_MS_OF_SEC = 10'd999;
    localparam int          SECONDS_W    = 16;

    // manual command codes
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // output tdata width
    localparam int OUT_TDATA_W = 24;

    typedef struct packed {
        logic [CFG_TIMER_W-1:0] debounce_ms;
        logic [CFG_TIMER_W-1:0] min_run_ms;
        logic [CFG_TIMER_W-1:0] sump_lockout_ms;
        logic [CFG_TIMER_W-1:0] tank_lockout_ms;
        logic [CFG_TIMER_W-1:0] manual_timeout_ms;
        logic [CFG_TIMER_W-1:0] flow_check_ms;
        logic [7:0]             min_rise_cm;
        logic [6:0]             normal_trigger_percent;
    } cfg_t;

    // input item without the distance, which follows a parameter
    typedef struct packed {
        logic       sump_wet_raw;
        logic [6:0] tank_percent;
        logic       distance_valid;
        logic       auto_enable;
        logic       top_up;
        logic [1:0] manual_command;
        logic       clear_flow_fault;
    } in_flags_t;

    typedef struct packed {
        logic                 relay_on;
        logic                 sump_water;
        logic                 filling;
        logic                 sump_locked;
        logic                 tank_locked;
        logic                 flow_locked;
        logic                 run_ended;
        logic [SECONDS_W-1:0] last_run_seconds;
    } out_item_t;

endpackage

@@ sv/pfsc_cfg_regs.sv @@
// pump fill safety controller: configuration register bank
// depends on pfsc_pkg
`timescale 1ns / 1ps

module pfsc_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [pfsc_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [pfsc_pkg::CFG_DATA_W-1:0]   wr_data,
    output pfsc_pkg::cfg_t                    cfg
);
    import pfsc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms            <= DEF_DEBOUNCE_MS;
            cfg_reg.min_run_ms             <= DEF_MIN_RUN_MS;
            cfg_reg.sump_lockout_ms        <= DEF_SUMP_LOCKOUT_MS;
            cfg_reg.tank_lockout_ms        <= DEF_TANK_LOCKOUT_MS;
            cfg_reg.manual_timeout_ms      <= DEF_MANUAL_TMO_MS;
            cfg_reg.flow_check_ms          <= DEF_FLOW_CHECK_MS;
            cfg_reg.min_rise_cm            <= DEF_MIN_RISE_CM;
            cfg_reg.normal_trigger_percent <= DEF_NORMAL_TRIG;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_DEBOUNCE:     cfg_reg.debounce_ms       <= wr_data;
                REG_MIN_RUN:      cfg_reg.min_run_ms        <= wr_data;
                REG_SUMP_LOCKOUT: cfg_reg.sump_lockout_ms   <= wr_data;
                REG_TANK_LOCKOUT: cfg_reg.tank_lockout_ms   <= wr_data;
                REG_MANUAL_TMO:   cfg_reg.manual_timeout_ms <= wr_data;
                REG_FLOW_CHECK:   cfg_reg.flow_check_ms     <= wr_data;
                REG_MIN_RISE:     cfg_reg.min_rise_cm       <= wr_data[7:0];
                REG_NORMAL_TRIG:  cfg_reg.normal_trigger_percent <= wr_data[6:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/pfsc_engine.sv @@
// pump fill safety controller: controller state and the per-tick update
// depends on pfsc_pkg; state advances on each tick taken from the input stage
`timescale 1ns / 1ps

module pfsc_engine
#(
    parameter int TIMER_BITS    = 24,
    parameter int DISTANCE_BITS = 10
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  pfsc_pkg::cfg_t             cfg,
    input  pfsc_pkg::in_flags_t        item,
    input  logic [DISTANCE_BITS-1:0]   distance,
    output pfsc_pkg::out_item_t        result
);
    import pfsc_pkg::*;

    localparam int CMP_W  = (TIMER_BITS > CFG_TIMER_W) ? TIMER_BITS : CFG_TIMER_W;
    localparam int RISE_W = DISTANCE_BITS + 1;

    typedef logic [TIMER_BITS-1:0]    tmr_t;
    typedef logic [CMP_W-1:0]         cmp_t;
    typedef logic [CFG_TIMER_W-1:0]   run_t;
    typedef logic [RISE_W-1:0]        rise_t;

    function automatic tmr_t tmr_inc(tmr_t v);
        return (&v) ? v : tmr_t'(v + 1'b1);
    endfunction

    function automatic logic tmr_ge(tmr_t v, run_t lim);
        return cmp_t'(v) >= cmp_t'(lim);
    endfunction

    logic                     relay_reg, relay_next;
    logic                     relay_prev_reg, relay_prev_next;
    logic                     sump_prev_raw_reg, sump_prev_raw_next;
    logic                     sump_stable_reg, sump_stable_next;
    logic                     flow_armed_reg, flow_armed_next;
    logic                     fill_reg, fill_next;
    logic                     sump_lk_reg, sump_lk_next;
    logic                     tank_lk_reg, tank_lk_next;
    logic                     flow_lk_reg, flow_lk_next;
    tmr_t                     debounce_cnt_reg, debounce_cnt_next;
    tmr_t                     sump_lock_cnt_reg, sump_lock_cnt_next;
    tmr_t                     tank_lock_cnt_reg, tank_lock_cnt_next;
    tmr_t                     manual_cnt_reg, manual_cnt_next;
    tmr_t                     flow_cnt_reg, flow_cnt_next;
    run_t                     run_time_reg, run_time_next;
    logic [SUBSEC_W-1:0]      run_subsec_reg, run_subsec_next;
    logic [SECONDS_W-1:0]     run_sec_reg, run_sec_next;
    logic [SECONDS_W-1:0]     last_run_reg, last_run_next;
    logic [DISTANCE_BITS-1:0] flow_ref_reg, flow_ref_next;
    logic                     ended;
    logic                     shield;
    logic [6:0]               trigger;

    always_comb
    begin
        relay_next         = relay_reg;
        relay_prev_next    = relay_prev_reg;
        flow_armed_next    = flow_armed_reg;
        fill_next          = fill_reg;
        sump_lk_next       = sump_lk_reg;
        tank_lk_next       = tank_lk_reg;
        flow_lk_next       = flow_lk_reg;
        sump_lock_cnt_next = sump_lock_cnt_reg;
        tank_lock_cnt_next = tank_lock_cnt_reg;
        flow_ref_next      = flow_ref_reg;
        last_run_next      = last_run_reg;
        run_time_next      = run_time_reg;
        run_subsec_next    = run_subsec_reg;
        run_sec_next       = run_sec_reg;
        ended              = 1'b0;
        shield             = 1'b0;
        trigger            = item.top_up ? TOPUP_TRIGGER : cfg.normal_trigger_percent;

        // time advances
        manual_cnt_next = tmr_inc(manual_cnt_reg);
        flow_cnt_next   = flow_armed_reg ? tmr_inc(flow_cnt_reg) : flow_cnt_reg;
        if (relay_prev_reg)
        begin
            run_time_next = (&run_time_reg) ? run_time_reg : run_t'(run_time_reg + 1'b1);
            if (run_subsec_reg == LAST_MS_OF_SEC)
            begin
                run_subsec_next = '0;
                run_sec_next    = (&run_sec_reg) ? run_sec_reg
                                                 : SECONDS_W'(run_sec_reg + 1'b1);
            end
            else
            begin
                run_subsec_next = SUBSEC_W'(run_subsec_reg + 1'b1);
            end
        end

        if (item.clear_flow_fault)
        begin
            flow_lk_next = 1'b0;
        end
        if (!item.auto_enable)
        begin
            if (item.manual_command == CMD_START)
            begin
                relay_next      = 1'b1;
                manual_cnt_next = '0;
            end
            else if (item.manual_command == CMD_STOP)
            begin
                relay_next = 1'b0;
            end
        end

        // relay edge
        if (relay_next && !relay_prev_reg)
        begin
            run_time_next   = '0;
            run_subsec_next = '0;
            run_sec_next    = '0;
            relay_prev_next = 1'b1;
        end
        else if (!relay_next && relay_prev_reg)
        begin
            last_run_next   = run_sec_next;
            relay_prev_next = 1'b0;
            ended           = 1'b1;
        end

        // float debounce
        debounce_cnt_next  = (item.sump_wet_raw != sump_prev_raw_reg) ? '0
                                                                      : tmr_inc(debounce_cnt_reg);
        sump_stable_next   = tmr_ge(debounce_cnt_next, cfg.debounce_ms) ? item.sump_wet_raw
                                                                        : sump_stable_reg;
        sump_prev_raw_next = item.sump_wet_raw;

        // lockout expiry
        if (sump_lk_reg)
        begin
            sump_lock_cnt_next = tmr_inc(sump_lock_cnt_reg);
            if (tmr_ge(sump_lock_cnt_next, cfg.sump_lockout_ms))
            begin
                sump_lk_next = 1'b0;
            end
        end
        if (tank_lk_reg)
        begin
            tank_lock_cnt_next = tmr_inc(tank_lock_cnt_reg);
            if (tmr_ge(tank_lock_cnt_next, cfg.tank_lockout_ms))
            begin
                tank_lk_next = 1'b0;
            end
        end

        // manual run timeout
        if (!item.auto_enable && relay_next && tmr_ge(manual_cnt_next, cfg.manual_timeout_ms))
        begin
            relay_next = 1'b0;
        end

        // automatic control
        if (item.auto_enable && item.distance_valid)
        begin
            shield = relay_next && (run_time_next < cfg.min_run_ms);

            if (!sump_stable_next && !sump_lk_next && !shield)
            begin
                sump_lk_next       = 1'b1;
                sump_lock_cnt_next = '0;
                relay_next         = 1'b0;
            end

            if (relay_next && !flow_lk_next && !shield)
            begin
                if (!flow_armed_next)
                begin
                    flow_armed_next = 1'b1;
                    flow_cnt_next   = '0;
                    flow_ref_next   = distance;
                end
                else if (tmr_ge(flow_cnt_next, cfg.flow_check_ms))
                begin
                    // rise = ref - distance compared against the least rise
                    if (rise_t'(flow_ref_next) <
                        rise_t'(rise_t'(distance) + rise_t'(cfg.min_rise_cm)))
                    begin
                        flow_lk_next = 1'b1;
                        relay_next   = 1'b0;
                    end
                    else
                    begin
                        flow_cnt_next = '0;
                        flow_ref_next = distance;
                    end
                end
            end
            else if (!relay_next)
            begin
                flow_armed_next = 1'b0;
            end

            if (item.tank_percent <= trigger && !tank_lk_next && !flow_lk_next)
            begin
                fill_next = 1'b1;
            end
            else if (item.tank_percent >= FULL_PERCENT && !shield)
            begin
                if (fill_next)
                begin
                    fill_next          = 1'b0;
                    relay_next         = 1'b0;
                    tank_lk_next       = 1'b1;
                    tank_lock_cnt_next = '0;
                end
            end

            if (fill_next && sump_stable_next && !sump_lk_next && !tank_lk_next &&
                !flow_lk_next)
            begin
                relay_next = 1'b1;
            end
            else if (relay_next && !shield)
            begin
                relay_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_reg         <= 1'b0;
            relay_prev_reg    <= 1'b0;
            sump_prev_raw_reg <= 1'b0;
            sump_stable_reg   <= 1'b0;
            flow_armed_reg    <= 1'b0;
            fill_reg          <= 1'b0;
            sump_lk_reg       <= 1'b0;
            tank_lk_reg       <= 1'b0;
            flow_lk_reg       <= 1'b0;
            debounce_cnt_reg  <= '0;
            sump_lock_cnt_reg <= '0;
            tank_lock_cnt_reg <= '0;
            manual_cnt_reg    <= '0;
            flow_cnt_reg      <= '0;
            run_time_reg      <= '0;
            run_subsec_reg    <= '0;
            run_sec_reg       <= '0;
            last_run_reg      <= '0;
            flow_ref_reg      <= '0;
        end
        else if (advance)
        begin
            relay_reg         <= relay_next;
            relay_prev_reg    <= relay_prev_next;
            sump_prev_raw_reg <= sump_prev_raw_next;
            sump_stable_reg   <= sump_stable_next;
            flow_armed_reg    <= flow_armed_next;
            fill_reg          <= fill_next;
            sump_lk_reg       <= sump_lk_next;
            tank_lk_reg       <= tank_lk_next;
            flow_lk_reg       <= flow_lk_next;
            debounce_cnt_reg  <= debounce_cnt_next;
            sump_lock_cnt_reg <= sump_lock_cnt_next;
            tank_lock_cnt_reg <= tank_lock_cnt_next;
            manual_cnt_reg    <= manual_cnt_next;
            flow_cnt_reg      <= flow_cnt_next;
            run_time_reg      <= run_time_next;
            run_subsec_reg    <= run_subsec_next;
            run_sec_reg       <= run_sec_next;
            last_run_reg      <= last_run_next;
            flow_ref_reg      <= flow_ref_next;
        end
    end

    always_comb
    begin
        result.relay_on         = relay_next;
        result.sump_water       = sump_stable_next;
        result.filling          = fill_next;
        result.sump_locked      = sump_lk_next;
        result.tank_locked      = tank_lk_next;
        result.flow_locked      = flow_lk_next;
        result.run_ended        = ended;
        result.last_run_seconds = last_run_next;
    end

endmodule

@@ sv/pump_fill_safety_controller_core.sv @@
// pump fill safety controller top level: requests pass the tick register and the result
// register; one tick per cycle while m_tready is high; the tick register feeds the
// update logic, which writes the result register and controller state in the same edge
// reset (rst_n, async, low) clears both pipeline stages, all timers and flags, and loads
// the register defaults; no clearing pass, the block takes requests right after reset
// depends on pfsc_pkg, pfsc_cfg_regs, pfsc_engine
`timescale 1ns / 1ps

module pump_fill_safety_controller_core
#(
    parameter int TIMER_BITS    = 24,
    parameter int DISTANCE_BITS = 10,
    parameter int IN_TDATA_W    = ((DISTANCE_BITS + 14 + 7) / 8) * 8
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // tick requests
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata from bit 0: sump_wet_raw, tank_percent(7), tank_distance_cm(DISTANCE_BITS),
    // distance_valid, auto_enable, top_up, manual_command(2), clear_flow_fault, zero fill
    input  logic [IN_TDATA_W-1:0]             s_tdata,
    // results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata from bit 0: relay_on, sump_water, filling, sump_locked, tank_locked,
    // flow_locked, run_ended, last_run_seconds(16), zero fill
    output logic [pfsc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pfsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pfsc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pfsc_pkg::*;

    localparam int DB = DISTANCE_BITS;

    cfg_t                 cfg;
    in_flags_t            in_item_reg;
    logic [DB-1:0]        in_dist_reg;
    logic                 in_valid_reg;
    out_item_t            out_item_reg;
    logic                 out_valid_reg;
    out_item_t            step_result;
    logic                 advance;
    logic                 in_take;

    // config writes are always accepted
    assign cfg_ready = 1'b1;

    pfsc_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // tick moves from the input stage into the result stage when the result stage
    // is empty or being drained this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.sump_wet_raw     <= s_tdata[0];
            in_item_reg.tank_percent     <= s_tdata[7:1];
            in_dist_reg                  <= s_tdata[DB+7:8];
            in_item_reg.distance_valid   <= s_tdata[DB+8];
            in_item_reg.auto_enable      <= s_tdata[DB+9];
            in_item_reg.top_up           <= s_tdata[DB+10];
            in_item_reg.manual_command   <= s_tdata[DB+12:DB+11];
            in_item_reg.clear_flow_fault <= s_tdata[DB+13];
        end
    end

    // timers, debounce, lockouts and fill logic
    pfsc_engine
    #(
        .TIMER_BITS    (TIMER_BITS),
        .DISTANCE_BITS (DISTANCE_BITS)
    )
    u_engine
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .cfg      (cfg),
        .item     (in_item_reg),
        .distance (in_dist_reg),
        .result   (step_result)
    );

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_item_reg.last_run_seconds,
                       out_item_reg.run_ended,
                       out_item_reg.flow_locked,
                       out_item_reg.tank_locked,
                       out_item_reg.sump_locked,
                       out_item_reg.filling,
                       out_item_reg.sump_water,
                       out_item_reg.relay_on};

endmodule

@@ sv/pfsc_checker.sv @@
// pump fill safety controller: port level checker and its bind to the top level
// depends on pfsc_pkg and pump_fill_safety_controller_core
`timescale 1ns / 1ps

module pfsc_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [pfsc_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import pfsc_pkg::*;

    // stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

    // a result that appears traces back to a taken request, through the tick and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a matching request");

    // an empty result stage never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
    else $error("input blocked with empty result stage");

    // with both stages full, the input opens only when the result drains
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && !s_tready) |=> (s_tready == m_tready))
    else $error("input ready out of step with result drain");

endmodule

bind pump_fill_safety_controller_core pfsc_checker u_pfsc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
